>>> sv/mhld_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
// Used by mhld_front, mhld_queue, mhld_back and the top level; no dependencies.
package mhld_pkg;

  localparam int unsigned HeaderBytes = 9;
  localparam int unsigned PosW        = 4;
  localparam logic [PosW-1:0] PosMagicHi = 4'd0;
  localparam logic [PosW-1:0] PosMagicLo = 4'd1;
  localparam logic [PosW-1:0] PosVersion = 4'd2;
  localparam logic [PosW-1:0] PosReserved = 4'd3;
  localparam logic [PosW-1:0] PosType    = 4'd4;
  localparam logic [PosW-1:0] PosLenFirst = 4'd5;
  localparam logic [PosW-1:0] PosLast    = PosW'(HeaderBytes - 1);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] MagicReset   = 16'hCAFE;
  localparam logic [7:0]  VersionReset = 8'h01;
  localparam logic [15:0] MaxPayReset  = 16'd1023;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_MAGIC   = 2'd0,
    CFG_EXPECTED_VERSION = 2'd1,
    CFG_MAX_PAYLOAD      = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD     = 3'd0,
    KIND_EMPTY       = 3'd1,
    KIND_BAD_MAGIC   = 3'd2,
    KIND_BAD_VERSION = 3'd3,
    KIND_TOO_LONG    = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] frame_type;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

endpackage

>>> sv/magic_header_length_deframer_core.sv
// Length-prefixed message deframer. One byte is taken per clock cycle, every
// cycle, as long as the result queue has room; a result passes through the
// queue and then the output register, and the queue between the header parser
// and the output register lets the output stall while it has room without
// stopping the input. The 9-byte header carries big-endian magic, version,
// reserved, type and a 32-bit big-endian length; a failed check or an empty
// message gives one marker transfer with last set, and payload bytes pass out
// tagged with the header's type. Configuration writes are registered and are
// always accepted.
module magic_header_length_deframer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    kind_o,
  output logic [7:0]                    frame_type_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mhld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mhld_pkg::CfgDataW-1:0] cfg_data_i
);

  logic              space, push, q_valid, q_pop;
  mhld_pkg::result_t push_data, q_data, out_data;

  mhld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .space_i     (space),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mhld_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  mhld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o         = out_data.kind;
  assign frame_type_o   = out_data.frame_type;
  assign payload_byte_o = out_data.payload_byte;
  assign last_o         = out_data.last;

endmodule

>>> sv/mhld_front.sv
// Front end of the deframer: configuration registers, header collection,
// header checks and payload tagging. Depends on mhld_pkg.
module mhld_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mhld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mhld_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          space_i,
  output logic                          push_o,
  output mhld_pkg::result_t             push_data_o
);

  logic [15:0] exp_magic_q;
  logic [7:0]  exp_version_q;
  logic [15:0] max_payload_q;

  logic [mhld_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0] magic_q, magic_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] length_q, length_d;
  logic [15:0] remaining_q, remaining_d;
  logic        in_payload_q, in_payload_d;

  logic accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space_i;
  assign accept      = in_valid_i && space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_magic_q   <= mhld_pkg::MagicReset;
      exp_version_q <= mhld_pkg::VersionReset;
      max_payload_q <= mhld_pkg::MaxPayReset;
    end else if (cfg_valid_i) begin
      case (mhld_pkg::cfg_idx_e'(cfg_index_i))
        mhld_pkg::CFG_EXPECTED_MAGIC:   exp_magic_q   <= cfg_data_i;
        mhld_pkg::CFG_EXPECTED_VERSION: exp_version_q <= cfg_data_i[7:0];
        mhld_pkg::CFG_MAX_PAYLOAD:      max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      magic_q      <= '0;
      version_q    <= '0;
      type_q       <= '0;
      length_q     <= '0;
      remaining_q  <= '0;
      in_payload_q <= 1'b0;
    end else if (accept) begin
      pos_q        <= pos_d;
      magic_q      <= magic_d;
      version_q    <= version_d;
      type_q       <= type_d;
      length_q     <= length_d;
      remaining_q  <= remaining_d;
      in_payload_q <= in_payload_d;
    end
  end

  always_comb begin
    pos_d        = pos_q;
    magic_d      = magic_q;
    version_d    = version_q;
    type_d       = type_q;
    length_d     = length_q;
    remaining_d  = remaining_q;
    in_payload_d = in_payload_q;
    push_o       = 1'b0;
    push_data_o  = '{kind: mhld_pkg::KIND_PAYLOAD, frame_type: type_q,
                     payload_byte: 8'd0, last: 1'b1};

    if (in_payload_q) begin
      push_o                   = accept;
      push_data_o.payload_byte = data_byte_i;
      push_data_o.last         = (remaining_q <= 16'd1);
      if (remaining_q <= 16'd1) begin
        remaining_d  = '0;
        in_payload_d = 1'b0;
        pos_d        = '0;
      end else begin
        remaining_d = remaining_q - 16'd1;
      end
    end else begin
      case (pos_q)
        mhld_pkg::PosMagicHi:  magic_d   = {data_byte_i, 8'd0};
        mhld_pkg::PosMagicLo:  magic_d   = {magic_q[15:8], data_byte_i};
        mhld_pkg::PosVersion:  version_d = data_byte_i;
        mhld_pkg::PosReserved: ;
        mhld_pkg::PosType:     type_d    = data_byte_i;
        mhld_pkg::PosLenFirst: length_d  = {24'd0, data_byte_i};
        default:               length_d  = {length_q[23:0], data_byte_i};
      endcase

      if (pos_q != mhld_pkg::PosLast) begin
        pos_d = pos_q + 1'b1;
      end else begin
        // Header complete: magic beats version, version beats length.
        pos_d  = '0;
        push_o = accept;
        if (magic_q != exp_magic_q) begin
          push_data_o.kind = mhld_pkg::KIND_BAD_MAGIC;
        end else if (version_q != exp_version_q) begin
          push_data_o.kind = mhld_pkg::KIND_BAD_VERSION;
        end else if ((length_d[31:16] != 16'd0) || (length_d[15:0] > max_payload_q)) begin
          push_data_o.kind = mhld_pkg::KIND_TOO_LONG;
        end else if (length_d == 32'd0) begin
          push_data_o.kind = mhld_pkg::KIND_EMPTY;
        end else begin
          push_o       = 1'b0;
          remaining_d  = length_d[15:0];
          in_payload_d = 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/mhld_queue.sv
// Short result queue between the deframer front end and the output stage.
// Depends on mhld_pkg for the result type.
module mhld_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mhld_pkg::result_t push_data_i,
  output logic              space_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mhld_pkg::result_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  mhld_pkg::result_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign valid_o    = (count_q != '0);
  assign do_pop     = pop_i && valid_o;
  // A slot freed by this cycle's pop may be refilled in the same cycle.
  assign space_o    = (count_q != Full) || do_pop;
  assign pop_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> sv/mhld_back.sv
// Output stage of the deframer: holds one result for the downstream side.
// Depends on mhld_pkg for the result type.
module mhld_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mhld_pkg::result_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mhld_pkg::result_t out_data_o
);

  logic              valid_q;
  mhld_pkg::result_t data_q;
  logic              load;

  assign load        = !valid_q || out_ready_i;
  assign q_pop_o     = load && q_valid_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule
